@@ design/max_counter_task_scheduler_unit_defines.svh @@
// assertion macros of the scheduler, used by mcts_ctrl
`ifndef MAX_COUNTER_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define MAX_COUNTER_TASK_SCHEDULER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MCTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MCTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/mcts_pkg.sv @@
// types, constants and helpers of the counter/priority task scheduler
package mcts_pkg;

    localparam int TASK_SLOTS = 64;
    localparam int SLOT_W     = 6;
    localparam int CNT_W      = 8;
    localparam int PRIO_W     = 7;

    localparam logic [SLOT_W-1:0] TOP_SLOT = SLOT_W'(TASK_SLOTS - 1);

    localparam logic OP_WRITE    = 1'b0;
    localparam logic OP_SCHEDULE = 1'b1;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic              present;
        logic              runnable;
        logic [CNT_W-1:0]  counter_value;
        logic [PRIO_W-1:0] priority_value;
    } in_word_t;

    typedef struct packed {
        logic [SLOT_W-1:0] next_task;
        logic              switched;
        logic              recomputed;
    } out_word_t;

    typedef struct packed {
        logic              present;
        logic              runnable;
        logic [CNT_W-1:0]  counter;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_idx;
        entry_t            wr_entry;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_idx;
    } tbl_req_t;

    // contents of a slot that has not been written since reset
    function automatic entry_t rst_entry(input logic idle_slot);
        entry_t e;
        e.present  = idle_slot;
        e.runnable = idle_slot;
        e.counter  = '0;
        e.prio     = PRIO_W'(1);
        return e;
    endfunction

endpackage

@@ design/mcts_table.sv @@
// task table memory with per-slot written bits and registered read
module mcts_table (
    input  logic             clk,
    input  logic             rst_n,
    input  mcts_pkg::tbl_req_t req,
    output mcts_pkg::entry_t rd_entry
);
    import mcts_pkg::*;

    entry_t                  mem [TASK_SLOTS];
    logic [TASK_SLOTS-1:0]   written_reg;
    entry_t                  rd_data_reg;
    logic                    rd_written_reg;
    logic                    rd_idle_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_idx] <= req.wr_entry;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
            rd_idle_reg    <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.wr_idx] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_written_reg <= written_reg[req.rd_idx];
                rd_idle_reg    <= (req.rd_idx == '0);
            end
        end
    end

    assign rd_entry = rd_written_reg ? rd_data_reg : rst_entry(rd_idle_reg);

endmodule

@@ design/mcts_ctrl.sv @@
// scan / recompute sequencer of the scheduler
`include "max_counter_task_scheduler_unit_defines.svh"
module mcts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  mcts_pkg::in_word_t req,
    output mcts_pkg::tbl_req_t tbl_req,
    input  mcts_pkg::entry_t   rd_entry,
    output logic               res_valid,
    input  logic               res_ready,
    output mcts_pkg::out_word_t res
);
    import mcts_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_RECOMP = 3'd2;
    localparam logic [2:0] ST_EVAL   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic              iss_reg, iss_next;
    logic              p_vld_reg, p_vld_next;
    logic [SLOT_W-1:0] p_idx_reg, p_idx_next;
    logic              any_reg, any_next;
    logic [CNT_W-1:0]  top_reg, top_next;
    logic [SLOT_W-1:0] choice_reg, choice_next;
    logic              redone_reg, redone_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;

    logic              accept;
    logic [CNT_W-1:0]  new_cnt;
    logic [CNT_W-1:0]  cand_cnt;
    logic              refresh;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;

    // halved counter plus priority peaks at 254, no saturation needed
    assign new_cnt = {1'b0, rd_entry.counter[CNT_W-1:1]} + {1'b0, rd_entry.prio};
    assign refresh = (state_reg == ST_RECOMP) && rd_entry.present;
    assign cand_cnt = refresh ? new_cnt : rd_entry.counter;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        iss_next    = iss_reg;
        p_vld_next  = 1'b0;
        p_idx_next  = p_idx_reg;
        any_next    = any_reg;
        top_next    = top_reg;
        choice_next = choice_reg;
        redone_next = redone_reg;
        cur_next    = cur_reg;
        tbl_req     = '0;
        res_valid   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.op == OP_WRITE)
                    begin
                        tbl_req.wr_en             = (int'(req.slot) < TASK_SLOTS);
                        tbl_req.wr_idx            = req.slot;
                        tbl_req.wr_entry.present  = req.present;
                        tbl_req.wr_entry.runnable = req.runnable;
                        tbl_req.wr_entry.counter  = req.counter_value;
                        tbl_req.wr_entry.prio     = (req.priority_value == '0) ?
                                                    PRIO_W'(1) : req.priority_value;
                    end
                    else
                    begin
                        state_next  = ST_SCAN;
                        cnt_next    = TOP_SLOT;
                        iss_next    = 1'b1;
                        any_next    = 1'b0;
                        top_next    = '0;
                        choice_next = '0;
                        redone_next = 1'b0;
                    end
                end
            end
            ST_SCAN, ST_RECOMP:
            begin
                // read slot cnt while the previous slot's word is evaluated
                if (iss_reg)
                begin
                    tbl_req.rd_en = 1'b1;
                    tbl_req.rd_idx = cnt_reg;
                    cnt_next      = cnt_reg - SLOT_W'(1);
                    iss_next      = (cnt_reg != SLOT_W'(1));
                    p_vld_next    = 1'b1;
                    p_idx_next    = cnt_reg;
                end
                if (p_vld_reg)
                begin
                    if (refresh)
                    begin
                        tbl_req.wr_en            = 1'b1;
                        tbl_req.wr_idx           = p_idx_reg;
                        tbl_req.wr_entry         = rd_entry;
                        tbl_req.wr_entry.counter = new_cnt;
                    end
                    if (rd_entry.present && rd_entry.runnable &&
                        (!any_reg || (cand_cnt > top_reg)))
                    begin
                        any_next    = 1'b1;
                        top_next    = cand_cnt;
                        choice_next = p_idx_reg;
                    end
                    if (p_idx_reg == SLOT_W'(1))
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL:
            begin
                if (any_reg && (top_reg == '0) && !redone_reg)
                begin
                    state_next  = ST_RECOMP;
                    cnt_next    = TOP_SLOT;
                    iss_next    = 1'b1;
                    any_next    = 1'b0;
                    top_next    = '0;
                    choice_next = '0;
                    redone_next = 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    cur_next   = choice_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.next_task  = choice_reg;
    assign res.switched   = (choice_reg != cur_reg);
    assign res.recomputed = redone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            iss_reg    <= 1'b0;
            p_vld_reg  <= 1'b0;
            cur_reg    <= '0;
            cnt_reg    <= '0;
            p_idx_reg  <= '0;
            any_reg    <= 1'b0;
            top_reg    <= '0;
            choice_reg <= '0;
            redone_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            iss_reg    <= iss_next;
            p_vld_reg  <= p_vld_next;
            cur_reg    <= cur_next;
            cnt_reg    <= cnt_next;
            p_idx_reg  <= p_idx_next;
            any_reg    <= any_next;
            top_reg    <= top_next;
            choice_reg <= choice_next;
            redone_reg <= redone_next;
        end
    end

    `MCTS_ASSERT_NOW(a_rmw_no_overlap, tbl_req.wr_en && tbl_req.rd_en,
        tbl_req.wr_idx != tbl_req.rd_idx, "write-back hits the slot being read")
    `MCTS_ASSERT_NOW(a_single_recompute, (state_reg == ST_EVAL) && redone_reg,
        !any_reg || (top_reg != '0), "recompute left a zero best counter")
    `MCTS_ASSERT_NOW(a_idle_never_scanned, p_vld_reg,
        p_idx_reg != '0, "slot 0 entered the scan")
    `MCTS_ASSERT_NEXT(a_scan_leads_to_eval, p_vld_reg && (p_idx_reg == SLOT_W'(1)),
        state_reg == ST_EVAL, "scan end did not reach evaluation")

endmodule

@@ design/max_counter_task_scheduler_unit.sv @@
// top level of the counter/priority task scheduler
// A write word loads one task slot. A schedule word walks the task table from
// the highest slot down to slot 1, one slot per cycle through the table's
// single read port; when the best runnable counter is zero, a second walk
// rewrites every present counter in slots 1 and up as counter/2 + priority
// while picking again. The result then sits in an output register, so write
// words are still taken while it waits; a further schedule word runs its scan
// and holds at the end until that register is free. No clearing pass is
// needed after reset: unwritten slots read as their reset contents.
module max_counter_task_scheduler_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  mcts_pkg::in_word_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output mcts_pkg::out_word_t rsp
);
    import mcts_pkg::*;

    tbl_req_t  tbl_req;
    entry_t    rd_entry;
    logic      res_valid;
    logic      res_ready;
    out_word_t res;
    logic      rsp_valid_reg;
    out_word_t rsp_reg;

    mcts_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (tbl_req),
        .rd_entry (rd_entry)
    );

    mcts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .tbl_req   (tbl_req),
        .rd_entry  (rd_entry),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output word register
    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
